[src/ffha_pkg.sv]
// shared types and constants of the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int POOL_BYTES   = 16384;
    localparam int HEADER_BYTES = 24;
    localparam int OFF_W        = 14;
    localparam int SIZE_W       = 15;

    typedef enum logic [2:0] {
        ST_EXACT   = 3'd0,
        ST_SPLIT   = 3'd1,
        ST_NOMEM   = 3'd2,
        ST_BADFREE = 3'd3,
        ST_FREED   = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [SIZE_W-1:0]  request_size;
        logic [OFF_W-1:0]   payload_offset;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   granted_offset;
    } out_item_t;

    typedef struct packed {
        logic [OFF_W-1:0]   start;
        logic [SIZE_W-1:0]  size;
        logic               is_free;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_FIX,
        S_NB_RD,
        S_NB_CHK,
        S_PV_RD,
        S_PV_CHK,
        S_MERGE,
        S_DROP_RD,
        S_DROP_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    scan_rd;
        logic    scan_next;
        logic    hit_latch;
        logic    wr_exact;
        logic    ins_start;
        logic    ins_rd;
        logic    ins_wr;
        logic    ins_new;
        logic    ins_fix;
        logic    nb_rd;
        logic    nb_latch;
        logic    pv_rd;
        logic    pv_latch;
        logic    merge;
        logic    drop_rd;
        logic    drop_wr;
        logic    drop_end;
        logic    res_set;
        status_t res_status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic is_free_op;
        logic exact;
        logic can_split;
        logic ins_here;
        logic has_next;
        logic has_prev;
        logic drop_end;
    } stat_t;

endpackage

[src/ffha_ctrl.sv]
// sequencer of the first-fit heap allocator
`timescale 1ns / 1ps
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = stat.scan_end ? S_DONE : S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (!stat.hit)
                    state_next = S_SCAN_RD;
                else if (stat.is_free_op)
                    state_next = S_NB_RD;
                else if (!stat.exact && stat.can_split)
                    state_next = S_INS_RD;
                else
                    state_next = S_DONE;
            end
            S_INS_RD:   state_next = stat.ins_here ? S_INS_FIX : S_INS_WR;
            S_INS_WR:   state_next = S_INS_RD;
            S_INS_FIX:  state_next = S_DONE;
            S_NB_RD:    state_next = stat.has_next ? S_NB_CHK : S_PV_RD;
            S_NB_CHK:   state_next = S_PV_RD;
            S_PV_RD:    state_next = stat.has_prev ? S_PV_CHK : S_MERGE;
            S_PV_CHK:   state_next = S_MERGE;
            S_MERGE:    state_next = S_DROP_RD;
            S_DROP_RD:  state_next = stat.drop_end ? S_DONE : S_DROP_WR;
            S_DROP_WR:  state_next = S_DROP_RD;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_NOMEM;
        unique case (state_reg)
            S_IDLE:     cmd.capture = in_valid;
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = stat.is_free_op ? ST_BADFREE : ST_NOMEM;
                end
                else
                    cmd.scan_rd = 1'b1;
            end
            S_SCAN_CHK:
            begin
                if (!stat.hit)
                    cmd.scan_next = 1'b1;
                else if (stat.is_free_op)
                    cmd.hit_latch = 1'b1;
                else if (stat.exact)
                begin
                    cmd.wr_exact   = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_EXACT;
                end
                else if (stat.can_split)
                begin
                    cmd.hit_latch = 1'b1;
                    cmd.ins_start = 1'b1;
                end
                else
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOMEM;
                end
            end
            S_INS_RD:
            begin
                if (stat.ins_here)
                    cmd.ins_new = 1'b1;
                else
                    cmd.ins_rd = 1'b1;
            end
            S_INS_WR:   cmd.ins_wr = 1'b1;
            S_INS_FIX:
            begin
                cmd.ins_fix    = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_SPLIT;
            end
            S_NB_RD:    cmd.nb_rd    = stat.has_next;
            S_NB_CHK:   cmd.nb_latch = 1'b1;
            S_PV_RD:    cmd.pv_rd    = stat.has_prev;
            S_PV_CHK:   cmd.pv_latch = 1'b1;
            S_MERGE:    cmd.merge    = 1'b1;
            S_DROP_RD:
            begin
                if (stat.drop_end)
                begin
                    cmd.drop_end   = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_FREED;
                end
                else
                    cmd.drop_rd = 1'b1;
            end
            S_DROP_WR:  cmd.drop_wr  = 1'b1;
            S_DONE:     cmd.out_load = out_free;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

[src/ffha_dp.sv]
// block table memory, scan and shift indexes, merge arithmetic and result register
`timescale 1ns / 1ps
module ffha_dp
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  cmd_t      cmd,
    output stat_t     stat,
    output out_item_t out_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
    localparam entry_t INIT_ENTRY = '{start: '0,
                                      size: SIZE_W'(POOL_BYTES - HEADER_BYTES),
                                      is_free: 1'b1};

    entry_t mem [MAX_BLOCKS];

    in_item_t          item_reg;
    logic [CNT_W-1:0]  i_reg, j_reg, cnt_reg;
    logic              fresh_reg, rd_fresh_reg;
    entry_t            rd_q, rd_data;
    entry_t            e_reg, n_reg, p_reg;
    logic              nfree_reg, pfree_reg;
    logic [1:0]        drop_reg;
    status_t           pend_status_reg;
    logic [OFF_W-1:0]  pend_grant_reg;
    out_item_t         out_reg;

    logic              rd_en, wr_en;
    logic [CNT_W-1:0]  rd_addr, wr_addr;
    entry_t            wr_data;
    logic [CNT_W-1:0]  i_plus1, i_minus1, base;
    logic [SIZE_W:0]   start_hdr;
    logic [SIZE_W-1:0] ext_size, base_size;
    logic [1:0]        drop_new;
    logic [CNT_W:0]    j_drop;

    assign rd_data   = rd_fresh_reg ? INIT_ENTRY : rd_q;
    assign i_plus1   = i_reg + CNT_W'(1);
    assign i_minus1  = i_reg - CNT_W'(1);
    assign start_hdr = (SIZE_W+1)'(rd_data.start) + (SIZE_W+1)'(HEADER_BYTES);
    assign j_drop    = (CNT_W+1)'(j_reg) + (CNT_W+1)'(drop_reg);

    // status toward the sequencer
    always_comb
    begin
        stat.scan_end   = (i_reg == cnt_reg);
        stat.is_free_op = (item_reg.operation == OP_FREE);
        if (item_reg.operation == OP_FREE)
            stat.hit = !rd_data.is_free &&
                       (start_hdr == (SIZE_W+1)'(item_reg.payload_offset));
        else
            stat.hit = rd_data.is_free && (rd_data.size >= item_reg.request_size);
        stat.exact     = (rd_data.size == item_reg.request_size);
        stat.can_split = ((SIZE_W+1)'(rd_data.size) >
                          (SIZE_W+1)'(item_reg.request_size) + (SIZE_W+1)'(HEADER_BYTES))
                         && (cnt_reg < CNT_W'(MAX_BLOCKS));
        stat.ins_here  = (j_reg == i_plus1);
        stat.has_next  = (i_plus1 < cnt_reg);
        stat.has_prev  = (i_reg != '0);
        stat.drop_end  = (drop_reg == 2'd0) || (j_drop >= (CNT_W+1)'(cnt_reg));
    end

    // merged free block
    always_comb
    begin
        ext_size  = nfree_reg ? (n_reg.size + HDR) : '0;
        base_size = pfree_reg ? (p_reg.size + HDR + e_reg.size) : e_reg.size;
        base      = pfree_reg ? i_minus1 : i_reg;
        drop_new  = {1'b0, pfree_reg} + {1'b0, nfree_reg};
    end

    // memory port control
    always_comb
    begin
        rd_en   = cmd.scan_rd | cmd.ins_rd | cmd.nb_rd | cmd.pv_rd | cmd.drop_rd;
        rd_addr = i_reg;
        if (cmd.ins_rd)
            rd_addr = j_reg - CNT_W'(1);
        else if (cmd.nb_rd)
            rd_addr = i_plus1;
        else if (cmd.pv_rd)
            rd_addr = i_minus1;
        else if (cmd.drop_rd)
            rd_addr = j_drop[CNT_W-1:0];

        wr_en   = cmd.wr_exact | cmd.ins_wr | cmd.ins_new | cmd.ins_fix |
                  cmd.merge | cmd.drop_wr;
        wr_addr = i_reg;
        wr_data = '{start: rd_data.start, size: rd_data.size, is_free: 1'b0};
        if (cmd.ins_wr || cmd.drop_wr)
        begin
            wr_addr = j_reg;
            wr_data = rd_data;
        end
        else if (cmd.ins_new)
        begin
            wr_addr = i_plus1;
            wr_data.start   = e_reg.start + OFF_W'(HEADER_BYTES) +
                              item_reg.request_size[OFF_W-1:0];
            wr_data.size    = e_reg.size - item_reg.request_size - HDR;
            wr_data.is_free = 1'b1;
        end
        else if (cmd.ins_fix)
            wr_data = '{start: e_reg.start, size: item_reg.request_size, is_free: 1'b0};
        else if (cmd.merge)
        begin
            wr_addr = base;
            wr_data = '{start: pfree_reg ? p_reg.start : e_reg.start,
                        size: base_size + ext_size, is_free: 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[IDX_W-1:0]] <= wr_data;
        if (rd_en)
            rd_q <= mem[rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= CNT_W'(1);
            fresh_reg    <= 1'b1;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_fresh_reg <= fresh_reg && (rd_addr == '0);
            if (wr_en && (wr_addr == '0))
                fresh_reg <= 1'b0;
            if (cmd.ins_fix)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (cmd.drop_end)
                cnt_reg <= cnt_reg - CNT_W'(drop_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
            i_reg    <= '0;
        end
        if (cmd.scan_next)
            i_reg <= i_plus1;
        if (cmd.hit_latch)
        begin
            e_reg     <= rd_data;
            nfree_reg <= 1'b0;
            pfree_reg <= 1'b0;
        end
        if (cmd.nb_latch)
        begin
            n_reg     <= rd_data;
            nfree_reg <= rd_data.is_free;
        end
        if (cmd.pv_latch)
        begin
            p_reg     <= rd_data;
            pfree_reg <= rd_data.is_free;
        end
        if (cmd.ins_start)
            j_reg <= cnt_reg;
        else if (cmd.ins_wr)
            j_reg <= j_reg - CNT_W'(1);
        else if (cmd.merge)
        begin
            j_reg    <= base + CNT_W'(1);
            drop_reg <= drop_new;
        end
        else if (cmd.drop_wr)
            j_reg <= j_reg + CNT_W'(1);
        if (cmd.res_set)
        begin
            pend_status_reg <= cmd.res_status;
            if (cmd.res_status == ST_EXACT)
                pend_grant_reg <= start_hdr[OFF_W-1:0];
            else if (cmd.res_status == ST_SPLIT)
                pend_grant_reg <= e_reg.start + OFF_W'(HEADER_BYTES);
            else
                pend_grant_reg <= '0;
        end
        if (cmd.out_load)
            out_reg <= '{status: pend_status_reg, granted_offset: pend_grant_reg};
    end

    assign out_data = out_reg;

endmodule

[src/first_fit_heap_allocator_unit.sv]
// top level of the first-fit heap allocator with coalescing
// allocate: scan the table to the first fitting block, then shift later entries up to split it
// free: scan for the block, read its neighbors, merge, shift later entries down, then finish
// throughput: one item at a time; set by the block table, one entry read per step
// reset: table holds one free block covering the pool minus a header, no result pending
// the result register holds a reply until taken; the next item may be accepted meanwhile
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: scan, split insertion shift, neighbor merge, drop shift, reply transfer
    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // block table in a one-write one-read memory with registered read data
    ffha_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

[verif/first_fit_heap_allocator_checker.sv]
// checker for the first-fit heap allocator: predicts replies and compares transfers
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_replies
);

    // shadow block table
    logic [OFF_W-1:0]  tbl_start [MAX_BLOCKS];
    logic [SIZE_W:0]   tbl_size  [MAX_BLOCKS];
    logic              tbl_free  [MAX_BLOCKS];
    int                tbl_count;
    out_item_t         reply_queue[$];

    assign pending_replies = reply_queue.size();

    function automatic void remove_entry(int k);
        for (int j = k; j + 1 < tbl_count; j++)
        begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
            tbl_free[j]  = tbl_free[j+1];
        end
        tbl_count--;
        tbl_start[tbl_count] = '0;
        tbl_size[tbl_count]  = '0;
        tbl_free[tbl_count]  = 1'b0;
    endfunction

    function automatic void merge_with_next(int k);
        tbl_size[k] = (SIZE_W+1)'(int'(tbl_size[k]) + int'(tbl_size[k+1]) + HEADER_BYTES);
        remove_entry(k + 1);
    endfunction

    function automatic out_item_t heap_apply(in_item_t item);
        out_item_t r;
        int i;
        int req;
        int sz;
        r.status = ST_NOMEM;
        r.granted_offset = '0;
        if (item.operation == OP_ALLOC)
        begin
            req = int'(item.request_size);
            for (i = 0; i < tbl_count; i++)
                if (tbl_free[i] && int'(tbl_size[i]) >= req) break;
            if (i < tbl_count)
            begin
                sz = int'(tbl_size[i]);
                if (sz == req)
                begin
                    tbl_free[i] = 1'b0;
                    r.status = ST_EXACT;
                    r.granted_offset = OFF_W'(int'(tbl_start[i]) + HEADER_BYTES);
                end
                else if (sz > req + HEADER_BYTES && tbl_count < MAX_BLOCKS)
                begin
                    for (int j = tbl_count; j > i + 1; j--)
                    begin
                        tbl_start[j] = tbl_start[j-1];
                        tbl_size[j]  = tbl_size[j-1];
                        tbl_free[j]  = tbl_free[j-1];
                    end
                    tbl_start[i+1] = OFF_W'(int'(tbl_start[i]) + HEADER_BYTES + req);
                    tbl_size[i+1]  = (SIZE_W+1)'(sz - req - HEADER_BYTES);
                    tbl_free[i+1]  = 1'b1;
                    tbl_count++;
                    tbl_size[i] = (SIZE_W+1)'(req);
                    tbl_free[i] = 1'b0;
                    r.status = ST_SPLIT;
                    r.granted_offset = OFF_W'(int'(tbl_start[i]) + HEADER_BYTES);
                end
            end
        end
        else
        begin
            r.status = ST_BADFREE;
            for (i = 0; i < tbl_count; i++)
                if (!tbl_free[i] && int'(tbl_start[i]) + HEADER_BYTES
                    == int'(item.payload_offset)) break;
            if (i < tbl_count)
            begin
                tbl_free[i] = 1'b1;
                if (i + 1 < tbl_count && tbl_free[i+1]) merge_with_next(i);
                if (i > 0 && tbl_free[i-1]) merge_with_next(i - 1);
                r.status = ST_FREED;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_BLOCKS; j++)
            begin
                tbl_start[j] = '0;
                tbl_size[j]  = '0;
                tbl_free[j]  = 1'b0;
            end
            tbl_size[0] = (SIZE_W+1)'(POOL_BYTES - HEADER_BYTES);
            tbl_free[0] = 1'b1;
            tbl_count   = 1;
            fail_count  = 0;
            reply_queue.delete();
        end
        else
        begin
            // reply side first: a reply can never belong to a request taken on this edge
            if (out_valid && out_ready)
            begin
                if (reply_queue.size() == 0)
                begin
                    $display("%0t: unexpected reply, actual status=%0d offset=%0d",
                             $time, out_data.status, out_data.granted_offset);
                    fail_count++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.granted_offset !== want.granted_offset)
                    begin
                        $display("%0t: offset mismatch, expected %0d actual %0d",
                                 $time, want.granted_offset, out_data.granted_offset);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                reply_queue.push_back(heap_apply(in_data));
        end
    end

endmodule

[verif/first_fit_heap_allocator_unit_test.sv]
// testbench top of the first-fit heap allocator: stimulus and verdict
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit_test;
    import ffha_pkg::*;

    localparam int RUN_LIMIT = 1500000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_replies;
    int        cycle_count = 0;
    bit        hold_long;
    bit        hold_done = 1'b0;

    // offsets handed out so far, used to build well-formed frees
    logic [OFF_W-1:0] live_offsets[$];

    first_fit_heap_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    first_fit_heap_allocator_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .pending_replies (pending_replies)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one, sometimes none at all
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // one transfer on the request channel, offered at the falling edge
    task automatic send_request(op_t op, int size, int offset);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.operation      <= op;
        in_data.request_size   <= size[SIZE_W-1:0];
        in_data.payload_offset <= offset[OFF_W-1:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // replies show up later; the reply watcher records granted offsets
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready &&
            (out_data.status == ST_EXACT || out_data.status == ST_SPLIT))
            live_offsets.push_back(out_data.granted_offset);
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = gap_length();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic free_random_live();
        int k;
        logic [OFF_W-1:0] o;
        k = int'($urandom_range(0, live_offsets.size() - 1));
        o = live_offsets[k];
        live_offsets.delete(k);
        send_request(OP_FREE, int'($urandom_range(0, 32767)), int'(o));
    endtask

    initial
    begin
        int pick;
        int sz;
        in_valid    = 1'b0;
        in_data     = '0;
        hold_long   = 1'b0;
        rst_n       = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero size, small splits, exact reuse, bad frees, coalescing
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 100, 0);
        send_request(OP_ALLOC, 200, 0);
        send_request(OP_ALLOC, 300, 0);
        send_request(OP_FREE, 0, 48);            // middle block of 100 bytes
        send_request(OP_ALLOC, 100, 0);          // exact fit back into it
        send_request(OP_FREE, 0, 48);
        send_request(OP_ALLOC, 90, 0);           // fits by size, but remainder too small to split: no memory
        send_request(OP_FREE, 0, 48);            // already free, invalid
        send_request(OP_FREE, 0, 16383);         // not a block start
        send_request(OP_FREE, 32767, 0);         // offset below any payload
        send_request(OP_FREE, 0, 172);           // 200-byte block, merges with free left
        send_request(OP_FREE, 0, 396);           // 300-byte block, merges both sides
        send_request(OP_FREE, 0, 24);            // zero-size block, pool whole again
        send_request(OP_ALLOC, 16384, 0);        // too big
        send_request(OP_ALLOC, 32767, 0);        // all size bits set
        send_request(OP_ALLOC, POOL_BYTES - HEADER_BYTES, 0);  // whole pool, exact
        send_request(OP_FREE, 0, 24);
        // fill the table with tiny blocks until it is full
        repeat (66) send_request(OP_ALLOC, int'($urandom_range(0, 8)), 0);

        // long receiver hold-off while requests keep coming
        hold_long = 1'b1;
        repeat (20) send_request(OP_FREE, 0, int'($urandom_range(0, 16383)));
        in_valid <= 1'b0;
        wait (pending_replies == 0);
        repeat (10) @(negedge clk);
        live_offsets.delete();
        // pool state is whatever the directed part left; frees below rebuild it

        repeat (450)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 45)
            begin
                sz = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 32767))
                                                   : int'($urandom_range(0, 600));
                send_request(OP_ALLOC, sz, 0);
            end
            else if (pick < 88 && live_offsets.size() > 0)
                free_random_live();
            else
                send_request(OP_FREE, int'($urandom_range(0, 32767)),
                             int'($urandom_range(0, 16383)));
        end
        in_valid <= 1'b0;

        wait (pending_replies == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
